// ----- rtl/drrip_pkg.sv -----
`default_nettype none

package drrip_pkg;

   localparam int SETS           = 64;
   localparam int WAYS           = 16;
   localparam int PSEL_BITS      = 10;
   localparam int BIMODAL_PERIOD = 32;

   localparam int SET_BITS     = $clog2(SETS);
   localparam int WAY_BITS     = $clog2(WAYS);
   localparam int WAY_CNT_BITS = $clog2(WAYS + 1);
   localparam int BIM_BITS     = $clog2(BIMODAL_PERIOD);

   localparam logic [1:0] RRPV_TOP  = 2'd3;
   localparam logic [1:0] RRPV_LONG = 2'd2;
   localparam logic [1:0] RRPV_NEAR = 2'd0;

   localparam logic [PSEL_BITS-1:0] PSEL_TOP = {PSEL_BITS{1'b1}};
   localparam logic [PSEL_BITS-1:0] PSEL_MID = PSEL_BITS'(1 << (PSEL_BITS - 1));
   localparam logic [BIM_BITS-1:0]  BIM_LAST = BIM_BITS'(BIMODAL_PERIOD - 1);

   localparam logic [3:0] MONITORS_MAX = 4'd8;

   localparam logic [3:0] MONITOR_SETS_RESET = 4'd4;
   localparam logic [4:0] ACTIVE_WAYS_RESET  = 5'd16;

   localparam int CSR_ADDR_BITS = 3;

   typedef enum logic {
      REG_MONITOR_SETS = 1'b0,
      REG_ACTIVE_WAYS  = 1'b1
   } reg_index_type;

   typedef enum logic {
      KIND_HIT  = 1'b0,
      KIND_MISS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ROLE_FOLLOWER = 2'd0,
      ROLE_SRRIP    = 2'd1,
      ROLE_BRRIP    = 2'd2
   } role_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic       kind;
      logic [5:0] set_index;
      logic [3:0] hit_way;
   } req_type;

   typedef struct packed {
      logic [3:0] victim_way;
      logic [1:0] inserted_rrpv;
      logic       used_srrip;
      logic [1:0] set_role;
   } rsp_type;

   typedef struct packed {
      logic [3:0] monitor_sets;
      logic [4:0] active_ways;
   } cfg_type;

   typedef logic [WAYS-1:0][1:0] row_type;

endpackage

`default_nettype wire

// ----- rtl/drrip_csr.sv -----
`default_nettype none

module drrip_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire [drrip_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire [31:0]                          pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output drrip_pkg::cfg_type                  cfg
);
   import drrip_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_beat;

   assign index      = reg_index_type'(paddr[2]);
   assign pready     = 1'b1;
   assign write_beat = psel && penable && pwrite && pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_beat) begin
         unique case (index)
            REG_MONITOR_SETS: cfg_in.monitor_sets = pwdata[3:0];
            REG_ACTIVE_WAYS:  cfg_in.active_ways  = pwdata[4:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_MONITOR_SETS: prdata = {28'd0, cfg_ff.monitor_sets};
         REG_ACTIVE_WAYS:  prdata = {27'd0, cfg_ff.active_ways};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.monitor_sets <= MONITOR_SETS_RESET;
         cfg_ff.active_ways  <= ACTIVE_WAYS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/drrip_row_store.sv -----
`default_nettype none

module drrip_row_store (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            rd_en,
   input  wire [drrip_pkg::SET_BITS-1:0]  rd_addr,
   output drrip_pkg::row_type             rd_row,
   input  wire                            wr_en,
   input  wire [drrip_pkg::SET_BITS-1:0]  wr_addr,
   input  drrip_pkg::row_type             wr_row
);
   import drrip_pkg::*;

   row_type           mem [SETS];
   logic [SETS-1:0]   row_valid_ff;
   row_type           rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         rd_row[w] = rd_valid_ff ? rd_data_ff[w] : RRPV_TOP;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/drrip_row_update.sv -----
`default_nettype none

module drrip_row_update (
   input  drrip_pkg::row_type                row,
   input  wire                               miss,
   input  wire [3:0]                         hit_way,
   input  wire [drrip_pkg::WAY_CNT_BITS-1:0] ways_eff,
   input  wire [1:0]                         fill,
   output drrip_pkg::row_type                new_row,
   output logic [drrip_pkg::WAY_BITS-1:0]    victim
);
   import drrip_pkg::*;

   logic [WAYS-1:0] active;
   logic            has3;
   logic            has2;
   logic            has1;
   logic [1:0]      age;
   row_type         aged;
   logic [WAY_BITS-1:0] miss_victim;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         active[w] = WAY_CNT_BITS'(w) < ways_eff;
      end
   end

   always_comb begin
      has3 = 1'b0;
      has2 = 1'b0;
      has1 = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         has3 = has3 | (active[w] && row[w] == 2'd3);
         has2 = has2 | (active[w] && row[w] == 2'd2);
         has1 = has1 | (active[w] && row[w] == 2'd1);
      end
      if (has3) begin
         age = 2'd0;
      end else if (has2) begin
         age = 2'd1;
      end else if (has1) begin
         age = 2'd2;
      end else begin
         age = 2'd3;
      end
   end

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         aged[w] = active[w] ? 2'(row[w] + age) : row[w];
      end
      miss_victim = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (active[w] && aged[w] == RRPV_TOP) begin
            miss_victim = WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      if (miss) begin
         new_row              = aged;
         new_row[miss_victim] = fill;
         victim               = miss_victim;
      end else begin
         new_row = row;
         if ({1'b0, hit_way} < WAY_CNT_BITS'(ways_eff)) begin
            new_row[hit_way[WAY_BITS-1:0]] = RRPV_NEAR;
         end
         victim = hit_way[WAY_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/drrip_policy.sv -----
`default_nettype none

module drrip_policy (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [3:0]            monitor_sets,
   input  wire [5:0]            set_index,
   input  wire                  miss_commit,
   output drrip_pkg::role_type  role,
   output logic                 srrip,
   output logic [1:0]           fill
);
   import drrip_pkg::*;

   logic [PSEL_BITS-1:0] psel_ff;
   logic [PSEL_BITS-1:0] psel_in;
   logic [BIM_BITS-1:0]  bim_ff;
   logic [BIM_BITS-1:0]  bim_in;
   logic [BIM_BITS-1:0]  bim_next;
   logic [3:0]           monitors;
   logic [4:0]           twice;

   always_comb begin
      if (monitor_sets == 4'd0) begin
         monitors = 4'd1;
      end else if (monitor_sets > MONITORS_MAX) begin
         monitors = MONITORS_MAX;
      end else begin
         monitors = monitor_sets;
      end
      twice = {monitors, 1'b0};
      if (set_index < {2'b00, monitors}) begin
         role = ROLE_SRRIP;
      end else if (set_index < {1'b0, twice}) begin
         role = ROLE_BRRIP;
      end else begin
         role = ROLE_FOLLOWER;
      end
   end

   always_comb begin
      bim_next = (bim_ff == BIM_LAST) ? '0 : BIM_BITS'(bim_ff + 1'b1);
      unique case (role)
         ROLE_SRRIP:    srrip = 1'b1;
         ROLE_BRRIP:    srrip = 1'b0;
         ROLE_FOLLOWER: srrip = psel_ff >= PSEL_MID;
         default:       srrip = 1'b1;
      endcase
      if (srrip) begin
         fill = RRPV_LONG;
      end else begin
         fill = (bim_next == '0) ? RRPV_LONG : RRPV_TOP;
      end
   end

   always_comb begin
      psel_in = psel_ff;
      bim_in  = bim_ff;
      if (miss_commit) begin
         if (role == ROLE_SRRIP && psel_ff != '0) begin
            psel_in = PSEL_BITS'(psel_ff - 1'b1);
         end else if (role == ROLE_BRRIP && psel_ff != PSEL_TOP) begin
            psel_in = PSEL_BITS'(psel_ff + 1'b1);
         end
         if (!srrip) begin
            bim_in = bim_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psel_ff <= PSEL_MID;
         bim_ff  <= '0;
      end else begin
         psel_ff <= psel_in;
         bim_ff  <= bim_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/drrip_replacement_policy.sv -----
// DRRIP replacement policy with set dueling.
// Request channel (req_valid, req_ready, req_payload): one beat per cache
// access; kind selects a hit on hit_way or a miss that needs a victim.
// Response channel (rsp_valid, rsp_ready, rsp_payload): one beat per request
// with the victim way, the RRPV written, the insertion policy and set role.
// Configuration: APB port, monitor_sets at byte address 0, active_ways at 4;
// write only while no request is outstanding.
// Each set keeps one 2-bit RRPV per way in a single row of the RRPV memory.
// The row is read at the accept edge; in the lookup state it is then updated,
// written back and the response registered once the output register is free.
// The next request is taken only in idle after that, so a request is not
// accepted before the previous one has been written back.
// rsp_valid rises at the write-back edge.
// Reset clears per-row valid bits so every row reads as all RRPV 3, sets the
// selector to its midpoint and the bimodal counter to 0; no clearing pass.
// A new request is accepted while a response still waits in the output
// register; if rsp_ready stays low the second request holds in its lookup
// cycle until the output register frees.
`default_nettype none

module drrip_replacement_policy (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  drrip_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output drrip_pkg::rsp_type                  rsp_payload,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire [drrip_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire [31:0]                          pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import drrip_pkg::*;

   state_type state_ff;
   state_type state_in;
   req_type   item_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_ff;
   cfg_type   cfg;
   row_type   rd_row;
   row_type   new_row;
   logic [WAY_BITS-1:0]     victim;
   logic [WAY_CNT_BITS-1:0] ways_eff;
   role_type  role;
   logic      srrip;
   logic [1:0] fill;
   logic      accept;
   logic      commit;
   logic      miss;

   assign accept    = req_valid && req_ready;
   assign miss      = item_ff.kind == KIND_MISS;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      if (cfg.active_ways == 5'd0) begin
         ways_eff = WAY_CNT_BITS'(1);
      end else if (cfg.active_ways > 5'(WAYS)) begin
         ways_eff = WAY_CNT_BITS'(WAYS);
      end else begin
         ways_eff = WAY_CNT_BITS'(cfg.active_ways);
      end
   end

   drrip_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   drrip_row_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_payload.set_index[SET_BITS-1:0]),
      .rd_row  (rd_row),
      .wr_en   (commit),
      .wr_addr (item_ff.set_index[SET_BITS-1:0]),
      .wr_row  (new_row)
   );

   drrip_policy u_policy (
      .clock        (clock),
      .reset        (reset),
      .monitor_sets (cfg.monitor_sets),
      .set_index    (item_ff.set_index),
      .miss_commit  (commit && miss),
      .role         (role),
      .srrip        (srrip),
      .fill         (fill)
   );

   drrip_row_update u_update (
      .row      (rd_row),
      .miss     (miss),
      .hit_way  (item_ff.hit_way),
      .ways_eff (ways_eff),
      .fill     (fill),
      .new_row  (new_row),
      .victim   (victim)
   );

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      commit       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
      if (commit) begin
         rsp_ff.set_role <= role;
         if (miss) begin
            rsp_ff.victim_way    <= 4'(victim);
            rsp_ff.inserted_rrpv <= fill;
            rsp_ff.used_srrip    <= srrip;
         end else begin
            rsp_ff.victim_way    <= item_ff.hit_way;
            rsp_ff.inserted_rrpv <= RRPV_NEAR;
            rsp_ff.used_srrip    <= 1'b0;
         end
      end
   end

   a_accept_then_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOKUP)
      else $error("accepted beat did not enter lookup");

   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP))
      else $error("response raised without a lookup");

   a_srrip_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.used_srrip) |-> rsp_ff.inserted_rrpv == RRPV_LONG)
      else $error("SRRIP fill not at long interval");

   a_role_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.set_role != 2'd3)
      else $error("bad set role");

endmodule

`default_nettype wire
